@@ src/uvst_pkg.sv @@
// Shared types and constants for the unique value set table.
// No dependencies; every other file of the block imports this package.
package uvst_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int ACT_W  = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 3;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);

  // stream payload widths, rounded up to whole bytes
  localparam int IN_BITS      = ACT_W + DATA_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 1 + DATA_W + CNT_W + STAT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_MOVE,
    S_READ,
    S_RESULT
  } eng_state_t;

  typedef struct packed {
    action_t                action;
    logic [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]       position;
  } cmd_t;

  typedef struct packed {
    logic              present;
    logic [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]  entry_count;
    status_t           status;
  } res_t;

endpackage

@@ src/uvst_front.sv @@
// Front end: takes input beats, decodes them into commands and queues them.
// Depends on uvst_pkg.
module uvst_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [uvst_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output uvst_pkg::cmd_t                  cmd
);
  import uvst_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push, pop;

  // tdata: action, value, position from bit 0 up
  always_comb begin
    dec.action   = action_t'(in_tdata[ACT_W-1:0]);
    dec.value    = VALUE_WIDTH'(in_tdata[ACT_W +: DATA_W]);
    dec.position = in_tdata[ACT_W+DATA_W +: POS_W];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

@@ src/uvst_engine.sv @@
// Back end: entry memory, linear search sequencer and result register.
// Depends on uvst_pkg.
module uvst_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  uvst_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output uvst_pkg::res_t out_res
);
  import uvst_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa, mem_ra;
  logic [VALUE_WIDTH-1:0] mem_wd;

  eng_state_t       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             pend_r, pend_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             rng_ok_r, rng_ok_nxt;
  res_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;
  logic             hit;
  logic             search_done;
  logic             out_free;

  // compare uses the registered read data, in the cycle after its address
  assign hit         = pend_r && (rd_data_r == cmd_r.value);
  assign search_done = hit || (!pend_r && (issue_r >= count_r));
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.action == ACT_READ) ? S_READ : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = (cmd_r.action == ACT_REMOVE && found_r) ? S_MOVE : S_RESULT;
      end
      S_MOVE:   state_nxt = S_RESULT;
      S_READ:   state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready     = 1'b0;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    rng_ok_nxt    = rng_ok_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_wa        = slot_r;
    mem_wd        = rd_data_r;
    mem_ra        = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          if (CNT_W'(cmd.position) < count_r) begin
            mem_ra     = IDX_W'(cmd.position);
            rng_ok_nxt = 1'b1;
          end else begin
            rng_ok_nxt = 1'b0;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = cmp_idx_r;
          pend_nxt  = 1'b0;
        end else if (issue_r < count_r) begin
          mem_ra      = issue_r[IDX_W-1:0];
          pend_nxt    = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_UPDATE: begin
        res_nxt.present     = found_r;
        res_nxt.entry_value = '0;
        res_nxt.status      = ST_DONE;
        case (cmd_r.action)
          ACT_ADD: begin
            if (found_r) begin
              res_nxt.status = ST_DUPLICATE;
            end else if (count_r >= CNT_W'(CAPACITY)) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = count_r[IDX_W-1:0];
              mem_wd    = cmd_r.value;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          ACT_REMOVE: begin
            if (found_r) begin
              // fetch the last entry; it fills the freed slot next cycle
              mem_ra    = IDX_W'(count_r - CNT_W'(1));
              count_nxt = count_r - CNT_W'(1);
            end else begin
              res_nxt.status = ST_NOT_FOUND;
            end
          end
          ACT_QUERY: res_nxt.status = found_r ? ST_DONE : ST_NOT_FOUND;
          default:   res_nxt.status = ST_DONE;
        endcase
      end
      S_MOVE: begin
        mem_we = 1'b1;
        mem_wa = slot_r;
        mem_wd = rd_data_r;
      end
      S_READ: begin
        res_nxt.present = 1'b0;
        res_nxt.status  = rng_ok_r ? ST_DONE : ST_RANGE;
        // out of range falls back to entry 0, or zero on an empty table
        if (rng_ok_r || count_r != '0) begin
          res_nxt.entry_value = DATA_W'(rd_data_r);
        end else begin
          res_nxt.entry_value = '0;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt             = res_r;
          out_res_nxt.entry_count = count_r;
        end
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    found_r   <= found_nxt;
    slot_r    <= slot_nxt;
    rng_ok_r  <= rng_ok_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ src/unique_value_set_table_core.sv @@
// Unique value set table: a set of up to 16 distinct 32-bit values. Commands
// are add, remove, query and read by index; each beat in gives exactly one
// result beat carrying presence, read data, the entry count and a status.
// A command queue of two beats decouples the input from the search engine,
// and a result register decouples the engine from the output. Add, remove
// and query scan the stored entries through the single read port of the
// entry memory, one entry per cycle; read by index reads its entry without
// a scan. A stalled result beat holds the engine until the result register
// is free. Commands are processed one at a time.
// Depends on uvst_pkg, uvst_front and uvst_engine.
module unique_value_set_table_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [uvst_pkg::IN_TDATA_W-1:0]  in_tdata,  // action, value, position
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [uvst_pkg::OUT_TDATA_W-1:0] out_tdata  // present, entry_value,
                                                      // entry_count, status
);
  import uvst_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  uvst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  uvst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = OUT_TDATA_W'({res.status, res.entry_count, res.entry_value,
                                   res.present});

endmodule

@@ src/uvst_checker.sv @@
// Port-level checks on the result stream of the set table, bound to the top.
// Depends on uvst_pkg and unique_value_set_table_core.
module uvst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [uvst_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import uvst_pkg::*;

  logic             present;
  logic [CNT_W-1:0] count;
  logic [STAT_W-1:0] status;

  assign present = out_tdata[0];
  assign count   = out_tdata[1+DATA_W +: CNT_W];
  assign status  = out_tdata[1+DATA_W+CNT_W +: STAT_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_DUPLICATE |-> present)
    else $error("duplicate reported for an absent value");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_FULL |-> !present && count == CNT_W'(CAPACITY))
    else $error("full rejection on a table that is not full");

  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ST_NOT_FOUND || status == ST_RANGE) |-> !present)
    else $error("present flag set on a miss or range error");

endmodule

bind unique_value_set_table_core uvst_checker u_uvst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/unique_value_set_table_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for unique_value_set_table_core: a directed table, then ~900 random
// commands, each checked against a behavioural model of the set held in the bench.
// Depends on uvst_pkg and the core RTL.
module unique_value_set_table_core_tb;
  import uvst_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_CMDS = 900;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic              present;
    logic [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]  entry_count;
    status_t           status;
  } set_reply_t;

  typedef struct {
    action_t           act;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
    int                reps;
    bit                known;
    set_reply_t        reply;
  } plan_row_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} cmd_mix_t;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // model of the set
  logic [DATA_W-1:0] set_slots [CAPACITY];
  int                set_size = 0;

  set_reply_t        pending_replies [$];
  plan_row_t         plan_rows [$];
  logic [DATA_W-1:0] value_pool [POOL_SIZE];
  int                accepted_cnt = 0;
  int                fail_cnt     = 0;
  int                cycle_cnt    = 0;
  int                burst_left   = 0;
  set_reply_t        got_reply;
  set_reply_t        want_reply;

  unique_value_set_table_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("unique_value_set_table_core_tb: FAIL");
      $finish;
    end
  end

  // Applies one command to the model set and returns the reply it should produce.
  function automatic set_reply_t apply_command(action_t act, logic [DATA_W-1:0] v,
                                               logic [POS_W-1:0] pos);
    set_reply_t r;
    int         hit;
    r   = '0;
    hit = -1;
    if (act != ACT_READ) begin
      for (int i = 0; i < set_size; i++)
        if (hit < 0 && set_slots[i] == v) hit = i;
      r.present = (hit >= 0);
      case (act)
        ACT_ADD: begin
          if (hit >= 0) r.status = ST_DUPLICATE;
          else if (set_size >= CAPACITY) r.status = ST_FULL;
          else begin
            set_slots[set_size] = v;
            set_size++;
          end
        end
        ACT_REMOVE: begin
          if (hit >= 0) begin
            // last entry fills the hole
            set_slots[hit] = set_slots[set_size-1];
            set_size--;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: r.status = (hit >= 0) ? ST_DONE : ST_NOT_FOUND;
      endcase
    end else if (int'(pos) < set_size) begin
      r.entry_value = set_slots[pos];
    end else begin
      r.status      = ST_RANGE;
      r.entry_value = (set_size > 0) ? set_slots[0] : '0;
    end
    r.entry_count = CNT_W'(set_size);
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_command(action_t act, logic [DATA_W-1:0] v,
                                                         logic [POS_W-1:0] pos);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[IN_BITS-1:0] = {pos, v, act};
    return w;
  endfunction

  function automatic set_reply_t unpack_reply(logic [OUT_TDATA_W-1:0] d);
    set_reply_t r;
    r.present     = d[0];
    r.entry_value = d[DATA_W:1];
    r.entry_count = d[DATA_W+CNT_W:DATA_W+1];
    r.status      = status_t'(d[DATA_W+CNT_W+STAT_W:DATA_W+CNT_W+1]);
    return r;
  endfunction

  task automatic plan_checked(action_t act, logic [DATA_W-1:0] v, logic [POS_W-1:0] pos,
                              int reps);
    plan_row_t row;
    row.act   = act;
    row.value = v;
    row.pos   = pos;
    row.reps  = reps;
    row.known = 1'b0;
    row.reply = '0;
    plan_rows.push_back(row);
  endtask

  task automatic plan_known(action_t act, logic [DATA_W-1:0] v, logic [POS_W-1:0] pos,
                            logic present, logic [DATA_W-1:0] entry, int count,
                            status_t status);
    plan_row_t row;
    row.act                 = act;
    row.value               = v;
    row.pos                 = pos;
    row.reps                = 1;
    row.known               = 1'b1;
    row.reply.present       = present;
    row.reply.entry_value   = entry;
    row.reply.entry_count   = CNT_W'(count);
    row.reply.status        = status;
    plan_rows.push_back(row);
  endtask

  // Holds one command on the input until it is taken, then books its reply.
  task automatic offer(action_t act, logic [DATA_W-1:0] v, logic [POS_W-1:0] pos,
                       bit known, set_reply_t known_reply);
    set_reply_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= pack_command(act, v, pos);
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = apply_command(act, v, pos);
    pending_replies.push_back(known ? known_reply : predicted);
    accepted_cnt++;
  endtask

  // Bursty sender: after a burst runs out, maybe drop valid for a random gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value(bit bool_member);
    if (bool_member && set_size > 0 && $urandom_range(0, 9) < 7)
      return set_slots[$urandom_range(0, set_size - 1)];
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic action_t pick_action(cmd_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   return (roll < 65) ? ACT_ADD : (roll < 75) ? ACT_REMOVE :
                         (roll < 85) ? ACT_QUERY : ACT_READ;
      MIX_SHRINK: return (roll < 10) ? ACT_ADD : (roll < 70) ? ACT_REMOVE :
                         (roll < 85) ? ACT_QUERY : ACT_READ;
      default:    return action_t'(roll % 4);
    endcase
  endfunction

  // Stimulus
  initial begin
    cmd_mix_t          mix;
    action_t           act;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0]  pos;
    plan_row_t         row;

    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    plan_known  (ACT_READ,   32'h0,         4'd0,  1'b0, 32'h0,         0,  ST_RANGE);
    plan_known  (ACT_QUERY,  32'h1234_5678, 4'd0,  1'b0, 32'h0,         0,  ST_NOT_FOUND);
    plan_known  (ACT_REMOVE, 32'h1234_5678, 4'd0,  1'b0, 32'h0,         0,  ST_NOT_FOUND);
    plan_known  (ACT_ADD,    32'h0,         4'd0,  1'b0, 32'h0,         1,  ST_DONE);
    plan_known  (ACT_ADD,    32'hFFFF_FFFF, 4'd15, 1'b0, 32'h0,         2,  ST_DONE);
    plan_known  (ACT_ADD,    32'h0,         4'd0,  1'b1, 32'h0,         2,  ST_DUPLICATE);
    plan_known  (ACT_READ,   32'hFFFF_FFFF, 4'd1,  1'b0, 32'hFFFF_FFFF, 2,  ST_DONE);
    plan_known  (ACT_READ,   32'h0,         4'd15, 1'b0, 32'h0,         2,  ST_RANGE);
    plan_known  (ACT_READ,   32'h0,         4'd2,  1'b0, 32'h0,         2,  ST_RANGE);
    plan_known  (ACT_QUERY,  32'hFFFF_FFFF, 4'd0,  1'b1, 32'h0,         2,  ST_DONE);
    plan_known  (ACT_REMOVE, 32'h0,         4'd0,  1'b1, 32'h0,         1,  ST_DONE);
    plan_known  (ACT_READ,   32'h0,         4'd3,  1'b0, 32'hFFFF_FFFF, 1,  ST_RANGE);
    plan_checked(ACT_ADD,    32'hA5A5_0000, 4'd0,  15);
    plan_known  (ACT_ADD,    32'h5A5A_5A5A, 4'd0,  1'b0, 32'h0,         16, ST_FULL);
    // duplicate check wins over the full check
    plan_known  (ACT_ADD,    32'hFFFF_FFFF, 4'd0,  1'b1, 32'h0,         16, ST_DUPLICATE);
    plan_known  (ACT_QUERY,  32'h5A5A_5A5A, 4'd0,  1'b0, 32'h0,         16, ST_NOT_FOUND);
    plan_checked(ACT_READ,   32'h0,         4'd15, 1);
    plan_checked(ACT_REMOVE, 32'hA5A5_0003, 4'd0,  1);
    plan_checked(ACT_READ,   32'h0,         4'd3,  1);
    plan_known  (ACT_REMOVE, 32'hA5A5_0003, 4'd0,  1'b0, 32'h0,         15, ST_NOT_FOUND);
    plan_known  (ACT_READ,   32'h0,         4'd15, 1'b0, 32'hFFFF_FFFF, 15, ST_RANGE);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_rows[r]) begin
      row = plan_rows[r];
      for (int k = 0; k < row.reps; k++) begin
        offer(row.act, row.value + k, row.pos, row.known, row.reply);
        pace();
      end
    end

    mix = MIX_EVEN;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 50 == 0) mix = cmd_mix_t'($urandom_range(0, 2));
      act = pick_action(mix);
      v   = pick_value(act != ACT_ADD);
      pos = POS_W'($urandom_range(0, 15));
      offer(act, v, pos, 1'b0, '0);
      if (n < RANDOM_CMDS - 1) pace();
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("unique_value_set_table_core_tb: PASS");
    end else begin
      $display("unique_value_set_table_core_tb: FAIL");
    end
    $finish;
  end

  // Receiver: changing stall patterns, plus two long hold-offs to back the block up
  initial begin
    rx_mode_t rx_mode;
    int       seg_left;
    int       phase;
    int       hold_left;
    int       holds_done;
    bit       ready_next;
    rx_mode    = RX_ALWAYS;
    seg_left   = 0;
    phase      = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        ready_next = 1'b0;
        hold_left--;
      end else if (holds_done < 2 && accepted_cnt >= (holds_done == 0 ? 200 : 650)) begin
        ready_next = 1'b0;
        hold_left  = HOLD_CYCLES;
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 80);
        end
        seg_left--;
        phase++;
        case (rx_mode)
          RX_ALWAYS: ready_next = 1'b1;
          RX_COIN:   ready_next = ($urandom_range(0, 1) == 1);
          RX_SPARSE: ready_next = (phase % 4 == 0);
          default:   ready_next = ($urandom_range(0, 7) != 0);
        endcase
      end
      out_tready <= ready_next;
    end
  end

  // Result beats against the oldest outstanding reply
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_reply = unpack_reply(out_tdata);
      if (pending_replies.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result beat: present=%0b value=%h count=%0d status=%0d",
                   $realtime, got_reply.present, got_reply.entry_value,
                   got_reply.entry_count, got_reply.status);
      end else begin
        want_reply = pending_replies.pop_front();
        if (got_reply.present !== want_reply.present ||
            got_reply.entry_value !== want_reply.entry_value ||
            got_reply.entry_count !== want_reply.entry_count ||
            got_reply.status !== want_reply.status) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: mismatch: exp present=%0b value=%h count=%0d status=%0d",
                     $realtime, want_reply.present, want_reply.entry_value,
                     want_reply.entry_count, want_reply.status);
            $display("          got present=%0b value=%h count=%0d status=%0d",
                     got_reply.present, got_reply.entry_value,
                     got_reply.entry_count, got_reply.status);
          end
        end
      end
    end
  end

endmodule

@@ files.f @@
src/uvst_pkg.sv
src/uvst_front.sv
src/uvst_engine.sv
src/unique_value_set_table_core.sv
src/uvst_checker.sv
test/unique_value_set_table_core_tb.sv
